>>> hdl/swbm_pkg.sv
// Shared types and constants of the sliding-window bitrate meter.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package swbm_pkg;

    // Field widths
    localparam int unsigned TIME_W      = 48;
    localparam int unsigned BYTES_W     = 16;
    localparam int unsigned WIN_W       = 24;
    localparam int unsigned OUT_BYTES_W = 26;
    localparam int unsigned RATE_W      = 29;

    // Stream packing
    localparam int unsigned S_TDATA_W = 72;   // time, direction, bytes = 65 bits
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 56;   // bytes, rate, overflow = 56 bits

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = WIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR    = 1'b1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 24'd250000;

    // Item kinds carried in s_tuser
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // bits per byte times ms per s
    localparam int unsigned KBPS_SCALE = 8000;
    localparam int unsigned SCALE_W    = 13;

    localparam logic [OUT_BYTES_W-1:0] BYTES_MAX = '1;
    localparam logic [RATE_W-1:0]      RATE_MAX  = '1;

    // Controller to datapath
    typedef struct packed {
        logic take_pkt;
        logic take_sample;
        logic cnt_rd;
        logic cnt_adv;
        logic drp_rd;
        logic drp_adv;
        logic mul_load;
        logic div_start;
        logic load_out;
    } swbm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_empty;
        logic cnt_hit;
        logic drp_empty;
        logic drp_hit;
        logic div_done;
        logic out_free;
    } swbm_status_t;

endpackage

`default_nettype wire

>>> hdl/sliding_window_bitrate_meter.sv
// Sliding-window bitrate meter, top level: controller plus datapath.
// Depends on swbm_pkg, swbm_controller, swbm_datapath (and swbm_divider below it).
//
// Usage:
//   The s_ channel carries packet records (s_tuser = 0) and sample requests
//   (s_tuser = 1) in time order. A packet of the selected direction is queued
//   as it is accepted, unless the queue is full, so packets stream at one
//   transaction per cycle while s_tready is high. A sample walks the queue
//   through the single memory read port: a read and a check for each entry
//   newly counted, a read and a check for each entry dropped from the window,
//   and a read, or a read and a check, to stop each of the two walks. Then a
//   multiply step, a divider start step, a shift step for each quotient bit,
//   a done step and a load step produce the kbps figure (quotient width 16 +
//   clog2(QUEUE_DEPTH + 1) + 13, 40 bits at the default depth). s_tready stays
//   low until the result is loaded. Each sample yields one m_ transaction;
//   packets yield none. The result sits in an output register: packets are
//   still accepted while it waits on a stalled m_tready, and a further sample
//   finishes its work and then holds until the register is free.
//   Reset (aresetn low, synchronous) empties the queue, clears the byte sum
//   and overflow flag, and loads window_us = 250000, direction_select = 0.
//   Write configuration through cfg_wr_en / cfg_index / cfg_wdata only when idle.
`default_nettype none

module sliding_window_bitrate_meter #(
    parameter int unsigned QUEUE_DEPTH = 1024
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration: index 0 window_us, index 1 direction_select
    input  wire logic                             cfg_wr_en,
    input  wire logic [swbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [swbm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: time_us[47:0], packet_direction[48], packet_bytes[64:49], zeros above
    input  wire logic [swbm_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: cmd[0]
    input  wire logic [swbm_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: byte_sum[25:0], rate_kbps[54:26], overflow[55]
    output logic [swbm_pkg::M_TDATA_W-1:0]        m_tdata
);

    import swbm_pkg::*;

    swbm_cmd_t    cmd;
    swbm_status_t status;

    swbm_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swbm_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_time   (s_tdata[TIME_W-1:0]),
        .in_dir    (s_tdata[TIME_W]),
        .in_bytes  (s_tdata[TIME_W+BYTES_W:TIME_W+1]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

>>> hdl/swbm_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Standalone; used by the datapath for the kbps division.
`default_nettype none

module swbm_divider #(
    parameter int unsigned N_W = 40,
    parameter int unsigned D_W = 24
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic      [N_W-1:0] quotient,
    output logic                done
);

    localparam int unsigned CNT_W = $clog2(N_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   q_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;

    logic [D_W:0] rem_shift;
    logic [D_W:0] rem_diff;
    logic         ge;

    // A zero divisor makes every step succeed, giving an all-ones quotient.
    assign rem_shift = {rem_reg, q_reg[N_W-1]};
    assign ge        = rem_shift >= {1'b0, div_reg};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // flag the last shift step
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[N_W-2:0], ge};
            rem_reg <= ge ? rem_diff[D_W-1:0] : rem_shift[D_W-1:0];
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

>>> hdl/swbm_datapath.sv
// Datapath: configuration registers, packet queue memory, walk pointers,
// byte sum, kbps scaling and division, output register. Uses swbm_pkg, swbm_divider.
`default_nettype none

module swbm_datapath #(
    parameter int unsigned QUEUE_DEPTH = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [swbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [swbm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [swbm_pkg::TIME_W-1:0]         in_time,
    input  wire logic                                in_dir,
    input  wire logic [swbm_pkg::BYTES_W-1:0]        in_bytes,
    input  wire swbm_pkg::swbm_cmd_t                 cmd,
    output swbm_pkg::swbm_status_t                   status,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [swbm_pkg::M_TDATA_W-1:0]           m_tdata
);

    import swbm_pkg::*;

    localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W   = BYTES_W + CNT_W;
    localparam int unsigned PROD_W  = SUM_W + SCALE_W;
    localparam int unsigned ENTRY_W = BYTES_W + TIME_W;
    localparam int unsigned CMP_W   = (SUM_W > OUT_BYTES_W) ? SUM_W : OUT_BYTES_W;

    logic [WIN_W-1:0]   window_reg;
    logic               dir_sel_reg;

    logic [ENTRY_W-1:0] queue_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]   newest_ptr_reg;
    logic [PTR_W-1:0]   counted_ptr_reg;
    logic [PTR_W-1:0]   oldest_ptr_reg;
    logic [CNT_W-1:0]   entry_cnt_reg;
    logic [CNT_W-1:0]   uncnt_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               ovf_reg;
    logic [TIME_W-1:0]  t_sample_reg;
    logic [PROD_W-1:0]  product_reg;

    logic                   m_tvalid_reg;
    logic [OUT_BYTES_W-1:0] m_bytes_reg;
    logic [RATE_W-1:0]      m_rate_reg;
    logic                   m_ovf_reg;

    logic [TIME_W-1:0]  rd_time;
    logic [BYTES_W-1:0] rd_size;
    logic [PTR_W-1:0]   rd_addr;
    logic               pkt_match;
    logic               queue_full;
    logic               pkt_wr;
    logic [TIME_W:0]    drop_limit;
    logic [PROD_W-1:0]  quotient;
    logic               div_done;
    logic [CMP_W-1:0]   sum_ext;
    logic [OUT_BYTES_W-1:0] bytes_sat;
    logic [RATE_W-1:0]      rate_sat;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign rd_time = rd_data_reg[TIME_W-1:0];
    assign rd_size = rd_data_reg[ENTRY_W-1:TIME_W];
    assign rd_addr = cmd.drp_rd ? oldest_ptr_reg : counted_ptr_reg;

    assign pkt_match  = in_dir == dir_sel_reg;
    assign queue_full = entry_cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign pkt_wr     = cmd.take_pkt && pkt_match && !queue_full;

    // Add in one extra bit so the window never wraps the threshold.
    assign drop_limit = {1'b0, rd_time} + (TIME_W + 1)'(window_reg);

    assign status.cnt_empty = uncnt_reg == '0;
    assign status.cnt_hit   = rd_time < t_sample_reg;
    assign status.drp_empty = entry_cnt_reg == uncnt_reg;
    assign status.drp_hit   = drop_limit < {1'b0, t_sample_reg};
    assign status.div_done  = div_done;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WINDOW_RESET;
            dir_sel_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WINDOW: window_reg  <= cfg_wdata;
                REG_DIR:    dir_sel_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Queue memory
    always_ff @(posedge aclk) begin
        if (pkt_wr) begin
            queue_mem[newest_ptr_reg] <= {in_bytes, in_time};
        end
        if (cmd.cnt_rd || cmd.drp_rd) begin
            rd_data_reg <= queue_mem[rd_addr];
        end
    end

    // Queue pointers, counts, byte sum, sticky overflow
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_ptr_reg  <= '0;
            counted_ptr_reg <= '0;
            oldest_ptr_reg  <= '0;
            entry_cnt_reg   <= '0;
            uncnt_reg       <= '0;
            sum_reg         <= '0;
            ovf_reg         <= 1'b0;
        end else begin
            if (cmd.take_pkt && pkt_match && queue_full) begin
                ovf_reg <= 1'b1;
            end
            if (pkt_wr) begin
                newest_ptr_reg <= next_slot(newest_ptr_reg);
                entry_cnt_reg  <= entry_cnt_reg + 1'b1;
                uncnt_reg      <= uncnt_reg + 1'b1;
            end else if (cmd.cnt_adv) begin
                sum_reg         <= sum_reg + SUM_W'(rd_size);
                counted_ptr_reg <= next_slot(counted_ptr_reg);
                uncnt_reg       <= uncnt_reg - 1'b1;
            end else if (cmd.drp_adv) begin
                sum_reg        <= sum_reg - SUM_W'(rd_size);
                oldest_ptr_reg <= next_slot(oldest_ptr_reg);
                entry_cnt_reg  <= entry_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_sample) begin
            t_sample_reg <= in_time;
        end
        if (cmd.mul_load) begin
            product_reg <= PROD_W'(sum_reg) * PROD_W'(KBPS_SCALE);
        end
    end

    swbm_divider #(
        .N_W (PROD_W),
        .D_W (WIN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (product_reg),
        .divisor  (window_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Saturate to the output field widths
    assign sum_ext   = CMP_W'(sum_reg);
    assign bytes_sat = (sum_ext > CMP_W'(BYTES_MAX)) ? BYTES_MAX : OUT_BYTES_W'(sum_ext);
    assign rate_sat  = (quotient > PROD_W'(RATE_MAX)) ? RATE_MAX : RATE_W'(quotient);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_bytes_reg <= bytes_sat;
            m_rate_reg  <= rate_sat;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_ovf_reg, m_rate_reg, m_bytes_reg};

endmodule

`default_nettype wire

>>> hdl/swbm_controller.sv
// Controller state machine: input handshake, count and drop walks,
// division sequencing and result hand-off. Uses swbm_pkg.
`default_nettype none

module swbm_controller (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_cmd,
    output logic                         s_tready,
    input  wire swbm_pkg::swbm_status_t  status,
    output swbm_pkg::swbm_cmd_t          cmd
);

    import swbm_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_CNT_RD    = 9'b000000010,
        ST_CNT_CHK   = 9'b000000100,
        ST_DRP_RD    = 9'b000001000,
        ST_DRP_CHK   = 9'b000010000,
        ST_MUL       = 9'b000100000,
        ST_DIV_START = 9'b001000000,
        ST_DIV_WAIT  = 9'b010000000,
        ST_DONE      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_fire;

    assign s_tready = state_reg == ST_IDLE;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.take_pkt    = s_fire && (s_cmd == CMD_PACKET);
        cmd.take_sample = s_fire && (s_cmd == CMD_SAMPLE);
        case (state_reg)
            ST_IDLE: begin
                if (cmd.take_sample) begin
                    state_next = ST_CNT_RD;
                end
            end
            ST_CNT_RD: begin
                if (status.cnt_empty) begin
                    state_next = ST_DRP_RD;
                end else begin
                    cmd.cnt_rd = 1'b1;
                    state_next = ST_CNT_CHK;
                end
            end
            ST_CNT_CHK: begin
                // stop at the first entry not older than the sample
                if (status.cnt_hit) begin
                    cmd.cnt_adv = 1'b1;
                    state_next  = ST_CNT_RD;
                end else begin
                    state_next = ST_DRP_RD;
                end
            end
            ST_DRP_RD: begin
                if (status.drp_empty) begin
                    state_next = ST_MUL;
                end else begin
                    cmd.drp_rd = 1'b1;
                    state_next = ST_DRP_CHK;
                end
            end
            ST_DRP_CHK: begin
                if (status.drp_hit) begin
                    cmd.drp_adv = 1'b1;
                    state_next  = ST_DRP_RD;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/swbm_checker.sv
// Port-level checker for the bitrate meter, bound to the top level.
// Sees only the stream ports; no package dependency.
`default_nettype none

module swbm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);

    // a stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // reset leaves no result and an open input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    // a sample closes the input while the walk runs
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("input open during sample walk");

    // a result never appears right after a sample is taken
    a_sample_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> !$rose(m_tvalid))
        else $error("result too early after sample");

endmodule

bind sliding_window_bitrate_meter swbm_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
